// ===== rtl/temp_sensor_poll_sequencer_top_defines.svh =====
// Assertion macros for the temperature sensor poll sequencer.
`ifndef TEMP_SENSOR_POLL_SEQUENCER_TOP_DEFINES_SVH
`define TEMP_SENSOR_POLL_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSPS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TSPS_ASSERT(lbl, prop, msg)
`define TSPS_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/tsps_pkg.sv =====
// Types, constants and helpers shared by the poll sequencer modules.
package tsps_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned RES_W = 4;
  localparam int unsigned WAIT_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RESOLUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REDISCOVER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REQUEST = 2'd2;

  localparam logic [RES_W-1:0] RES_RESET = 4'd10;
  localparam logic [PERIOD_W-1:0] REDISCOVER_RESET = 16'd2000;
  localparam logic [PERIOD_W-1:0] REQUEST_RESET = 16'd200;

  localparam logic [RES_W-1:0] RES_9 = 4'd9;
  localparam logic [RES_W-1:0] RES_10 = 4'd10;
  localparam logic [RES_W-1:0] RES_11 = 4'd11;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd880;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_BAD = 12'sd1360;

  typedef struct packed {
    logic [TIME_W-1:0]        now_ms;
    logic                     sensor_present;
    logic signed [TEMP_W-1:0] temp_raw;
  } in_item_t;

  typedef struct packed {
    logic                     do_discover;
    logic                     do_request;
    logic                     do_read;
    logic                     sensor_found;
    logic                     value_valid;
    logic signed [TEMP_W-1:0] temperature;
  } out_item_t;

  typedef struct packed {
    logic [RES_W-1:0]    resolution_bits;
    logic [PERIOD_W-1:0] rediscover_period;
    logic [PERIOD_W-1:0] request_period;
  } cfg_t;

  typedef struct packed {
    logic                     found;
    logic                     valid;
    logic                     pending;
    logic [TIME_W-1:0]        last_discover;
    logic [TIME_W-1:0]        last_request;
    logic [TIME_W-1:0]        conv_start;
    logic signed [TEMP_W-1:0] temperature;
  } poll_state_t;

  function automatic logic [WAIT_W-1:0] conv_wait(input logic [RES_W-1:0] res);
    logic [WAIT_W-1:0] w;
    case (res)
      RES_9:   w = 10'd94;
      RES_10:  w = 10'd188;
      RES_11:  w = 10'd375;
      default: w = 10'd750;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tsps_step.sv =====
// Next-state and result logic for one millisecond tick.
module tsps_step
  import tsps_pkg::*;
(
  input  poll_state_t st,
  input  cfg_t        cfg,
  input  in_item_t    item,
  output poll_state_t st_nxt,
  output out_item_t   res
);

  logic [TIME_W-1:0] disc_age;
  logic [TIME_W-1:0] req_age;
  logic [TIME_W-1:0] conv_age;
  logic [TIME_W-1:0] start_mid;
  logic              pend_mid;
  logic              disc;
  logic              req;
  logic              rd;
  logic              temp_ok;

  always_comb begin
    st_nxt = st;
    disc_age = item.now_ms - st.last_discover;
    req_age = item.now_ms - st.last_request;
    disc = !st.found && (disc_age >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.rediscover_period});
    req = st.found && !st.pending &&
          (req_age >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.request_period});
    pend_mid = st.pending || req;
    start_mid = req ? item.now_ms : st.conv_start;
    conv_age = item.now_ms - start_mid;
    rd = st.found && pend_mid &&
         (conv_age >= {{(TIME_W-WAIT_W){1'b0}}, conv_wait(cfg.resolution_bits)});
    temp_ok = (item.temp_raw >= TEMP_MIN) && (item.temp_raw <= TEMP_MAX) &&
              (item.temp_raw != TEMP_BAD);

    if (disc) begin
      st_nxt.last_discover = item.now_ms;
      if (item.sensor_present) begin
        st_nxt.found = 1'b1;
        st_nxt.valid = 1'b0;
        st_nxt.pending = 1'b0;
        st_nxt.last_request = item.now_ms;
      end
    end
    if (req) begin
      st_nxt.pending = 1'b1;
      st_nxt.conv_start = item.now_ms;
      st_nxt.last_request = item.now_ms;
    end
    if (rd) begin
      st_nxt.pending = 1'b0;
      if (temp_ok) begin
        st_nxt.temperature = item.temp_raw;
        st_nxt.valid = 1'b1;
      end else begin
        st_nxt.found = 1'b0;
        st_nxt.valid = 1'b0;
      end
    end

    res.do_discover = disc;
    res.do_request = req;
    res.do_read = rd;
    res.sensor_found = st_nxt.found;
    res.value_valid = st_nxt.found && st_nxt.valid;
    res.temperature = st_nxt.temperature;
  end

endmodule

// ===== rtl/temp_sensor_poll_sequencer_top.sv =====
// Top level of the temperature sensor poll sequencer.
//
// One input beat is one millisecond tick: current time, the answer of a
// discovery attempt and a raw reading in 1/16 C. Each input beat yields
// exactly one result beat with the discover, request and read strobes for
// that tick, the found and valid flags and the last accepted temperature.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. A tick is latched in an input register, evaluated by the
// combinational step logic, and written to the output register; one beat is
// taken every cycle while results drain. If the receiver stalls, the result
// register holds; the input register fills behind it and in_stall rises
// until out_stall drops. Configuration (resolution, rediscovery period,
// request period) is written through cfg_we / cfg_index / cfg_wdata; the
// user must write it only while the block is idle, which the block does not
// enforce. Synchronous reset clears all flags and timers and restores the
// register defaults: resolution 10, rediscovery 2000 ms, request 200 ms.
`include "temp_sensor_poll_sequencer_top_defines.svh"
module temp_sensor_poll_sequencer_top
  import tsps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg_r;
  poll_state_t st_r;
  poll_state_t st_nxt;
  in_item_t    in_r;
  logic        in_valid_r;
  out_item_t   out_r;
  out_item_t   res;
  logic        out_valid_r;
  logic        advance;
  logic        in_take;

  assign advance = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take = in_valid && !in_stall;

  tsps_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resolution_bits <= RES_RESET;
      cfg_r.rediscover_period <= REDISCOVER_RESET;
      cfg_r.request_period <= REQUEST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_RESOLUTION: cfg_r.resolution_bits <= cfg_wdata[RES_W-1:0];
        CFG_IDX_REDISCOVER: cfg_r.rediscover_period <= cfg_wdata[PERIOD_W-1:0];
        CFG_IDX_REQUEST:    cfg_r.request_period <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `TSPS_NEVER(a_read_without_discover, out_valid_r && out_r.do_read && out_r.do_discover, "read and discover in one tick")
  `TSPS_NEVER(a_valid_implies_found, out_valid_r && out_r.value_valid && !out_r.sensor_found, "value valid without sensor")
  `TSPS_ASSERT(a_request_keeps_found, out_valid_r && out_r.do_request |-> out_r.sensor_found, "request without sensor")
  `TSPS_ASSERT(a_stall_needs_item, in_stall |-> in_valid_r && out_valid_r && out_stall, "input stalled with no backlog")

endmodule
